FILE: design/preset_countdown_relay_timer_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the preset countdown relay timer
// Concurrent checks on clk with rst as the disable condition.
// ----------------------------------------------------------------------------
`ifndef PRESET_COUNTDOWN_RELAY_TIMER_TOP_ASSERT_SVH
`define PRESET_COUNTDOWN_RELAY_TIMER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define PCRT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pcrt: same-cycle check failed");

// Next-cycle implication.
`define PCRT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pcrt: next-cycle check failed");

`else

`define PCRT_ASSERT_IMP(lbl, ante, cons)
`define PCRT_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

FILE: design/pcrt_pkg.sv
// ----------------------------------------------------------------------------
// pcrt_pkg
// Types, constants and digit helpers for the preset countdown relay timer.
// ----------------------------------------------------------------------------
package pcrt_pkg;

  typedef enum logic [2:0] {
    CMD_TICK  = 3'd0,
    CMD_SLEEP = 3'd1,
    CMD_GRIND = 3'd2,
    CMD_LEFT  = 3'd3,
    CMD_RIGHT = 3'd4,
    CMD_UP    = 3'd5,
    CMD_DOWN  = 3'd6,
    CMD_LOAD  = 3'd7
  } cmd_t;

  localparam logic REG_PRESET_LIMIT = 1'b0;
  localparam logic REG_SLEEP_LIMIT  = 1'b1;

  localparam logic [10:0] PRESET_LIMIT_RST = 11'd1596;
  localparam logic [15:0] SLEEP_LIMIT_RST  = 16'd1830;

  // A decremented countdown above this mark has wrapped below zero.
  localparam logic [15:0] UNDERFLOW_MARK = 16'd60000;
  // A decremented preset above this mark has wrapped below zero.
  localparam logic [15:0] ROLLUNDER_MARK = 16'd65000;

  // The last member sits in the lowest bits, so relay_on lands in bit 0.
  typedef struct packed {
    logic [15:0] remaining_sixteenths;
    logic [1:0]  selected_slot;
    logic        display_asleep;
    logic        grind_done;
    logic        relay_on;
  } res_t;

  // floor(x / 10) for x below 2^19. The reciprocal is rounded down, so the
  // first estimate is short by at most one and one correction step fixes it.
  function automatic logic [15:0] div10(input logic [18:0] x);
    logic [34:0] prod;
    logic [15:0] q;
    logic [18:0] rem;
    prod = 35'(x) * 35'd52428;
    q    = prod[34:19];
    rem  = x - 19'(q) * 19'd10;
    if (rem >= 19'd10) begin
      q = q + 16'd1;
    end
    return q;
  endfunction

  // x mod 10 for x below 2^19, same estimate as div10.
  function automatic logic [3:0] rem10(input logic [18:0] x);
    logic [34:0] prod;
    logic [15:0] q;
    logic [18:0] rem;
    prod = 35'(x) * 35'd52428;
    q    = prod[34:19];
    rem  = x - 19'(q) * 19'd10;
    if (rem >= 19'd10) begin
      rem = rem - 19'd10;
    end
    return rem[3:0];
  endfunction

  // floor(x / 100) for a 12-bit x.
  function automatic logic [5:0] div100(input logic [11:0] x);
    logic [21:0] prod;
    logic [5:0]  q;
    logic [11:0] rem;
    prod = 22'(x) * 22'd655;
    q    = prod[21:16];
    rem  = x - 12'(q) * 12'd100;
    if (rem >= 12'd100) begin
      q = q + 6'd1;
    end
    return q;
  endfunction

endpackage

FILE: design/preset_countdown_relay_timer_top.sv
// ----------------------------------------------------------------------------
// preset_countdown_relay_timer_top
// Event-driven countdown timer with adjustable presets and a relay output.
// ----------------------------------------------------------------------------
// Usage:
//   Each input item on the s_ stream is one event (s_tuser): countdown tick,
//   sleep tick, grind, preset left/right/up/down, or a preset load that
//   carries a slot and a raw value in s_tdata. Every item yields exactly one
//   result item on the m_ stream: relay, done and sleep flags, the selected
//   slot, the countdown in sixteenths and its four display digits.
//   Each accepted item passes an input register, the state update into a
//   result register, then the digit split into the output register. One
//   item is accepted per cycle while the receiver keeps up; the state is
//   updated per item, so back-to-back events see each other's effects.
//   When the receiver stalls, the three stages fill and s_tready drops; no
//   item is lost or repeated. Reset (rst, synchronous) clears all presets,
//   the slot, countdown, relay and sleep state, empties the pipeline and
//   restores preset_limit to 1596 and sleep_limit to 1830.
//   Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once
//   and are meant to be made while the block is idle.
// ----------------------------------------------------------------------------
`include "preset_countdown_relay_timer_top_assert.svh"

module preset_countdown_relay_timer_top #(
  parameter int NUM_SLOTS = 4,
  parameter int STEP_SIZE = 4
) (
  input  logic        clk,
  input  logic        rst,
  // Input items
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [1:0] load_index, [17:2] load_value, rest zero
  input  logic [2:0]  s_tuser,   // [2:0] cmd
  // Result items
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [0] relay_on, [1] grind_done, [2] display_asleep,
                                 // [4:3] selected_slot, [20:5] remaining_sixteenths,
                                 // [24:21] tens_digit, [28:25] ones_digit,
                                 // [32:29] tenths_digit, [36:33] hundredths_digit
  // Configuration
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import pcrt_pkg::*;

  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int IDX_W  = (SLOT_W > 2) ? SLOT_W : 2;
  localparam int STEP_L = $clog2(STEP_SIZE);
  // Reciprocal for the multiple-of-step test on 16-bit values.
  localparam logic [16:0] STEP_M = 17'((64'd1 << (16 + STEP_L)) / STEP_SIZE + 1);

  // Pipeline control.
  logic out_move;
  logic b_move;
  logic a_move;
  logic b_load;

  // Input register.
  logic        a_valid;
  cmd_t        a_cmd;
  logic [1:0]  a_lidx;
  logic [15:0] a_lval;

  // State.
  logic [15:0]       store [NUM_SLOTS];
  logic [15:0]       sel_preset;   // copy of store[slot]
  logic [SLOT_W-1:0] slot;
  logic [15:0]       countdown;
  logic              running;
  logic [15:0]       sleep_count;
  logic              asleep;
  logic [10:0]       preset_limit;
  logic [15:0]       sleep_limit;

  // Result register.
  logic b_valid;
  res_t b_res;

  // Next-state logic.
  logic [15:0]       countdown_next;
  logic              running_next;
  logic [SLOT_W-1:0] slot_next;
  logic [15:0]       sel_preset_next;
  logic [15:0]       sleep_count_next;
  logic              asleep_next;
  logic              done_next;
  logic              store_we;
  logic [SLOT_W-1:0] store_waddr;
  logic [15:0]       store_wdata;

  logic [15:0]       cd_dec;
  logic [15:0]       sc_inc;
  logic [16:0]       up_sum;
  logic [15:0]       dn_diff;
  logic [SLOT_W-1:0] slot_left;
  logic [SLOT_W:0]   slot_inc;
  logic [SLOT_W-1:0] slot_right;
  logic [SLOT_W-1:0] slot_nb;
  logic [15:0]       nb_preset;
  logic [IDX_W-1:0]  lidx_w;
  logic [SLOT_W-1:0] lidx_s;
  logic              lidx_ok;
  logic [32:0]       step_prod;
  logic [15:0]       step_q;
  logic [15:0]       step_back;
  logic [15:0]       load_v;
  logic [IDX_W-1:0]  slot_w;

  // Digit split.
  logic [11:0] secs;
  logic [15:0] q10;
  logic [5:0]  q100;
  logic [8:0]  tens_w;
  logic [3:0]  tens_d;
  logic [3:0]  ones_d;
  logic [18:0] r5;
  logic [3:0]  tenths_d;
  logic [20:0] r25;
  logic [3:0]  hund_d;

  assign out_move = !m_tvalid || m_tready;
  assign b_move   = !b_valid || out_move;
  assign a_move   = !a_valid || b_move;
  assign s_tready = a_move;
  assign b_load   = a_valid && b_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_move) begin
      a_valid <= s_tvalid;
    end
    if (a_move && s_tvalid) begin
      a_cmd  <= cmd_t'(s_tuser[2:0]);
      a_lidx <= s_tdata[1:0];
      a_lval <= s_tdata[17:2];
    end
  end

  // Slot arithmetic and the neighbor preset read for left and right.
  assign slot_left  = (slot == '0) ? SLOT_W'(NUM_SLOTS - 1) : slot - 1'b1;
  assign slot_inc   = {1'b0, slot} + 1'b1;
  assign slot_right = (32'(slot_inc) >= NUM_SLOTS) ? '0 : slot_inc[SLOT_W-1:0];
  assign slot_nb    = (a_cmd == CMD_LEFT) ? slot_left : slot_right;
  assign nb_preset  = store[slot_nb];

  // Load validation: in range and a multiple of the step.
  assign lidx_w    = IDX_W'(a_lidx);
  assign lidx_s    = lidx_w[SLOT_W-1:0];
  assign lidx_ok   = 32'(a_lidx) < NUM_SLOTS;
  assign step_prod = 33'(a_lval) * 33'(STEP_M);
  assign step_q    = 16'(step_prod >> (16 + STEP_L));
  assign step_back = 16'(step_q * 16'(STEP_SIZE));
  assign load_v    = ((a_lval > 16'(preset_limit)) || (step_back != a_lval)) ? 16'd0 : a_lval;

  assign cd_dec  = countdown - 16'd1;
  assign sc_inc  = sleep_count + 16'd1;
  assign up_sum  = {1'b0, sel_preset} + 17'(STEP_SIZE);
  assign dn_diff = sel_preset - 16'(STEP_SIZE);

  always_comb begin
    countdown_next   = countdown;
    running_next     = running;
    slot_next        = slot;
    sel_preset_next  = sel_preset;
    sleep_count_next = sleep_count;
    asleep_next      = asleep;
    done_next        = 1'b0;
    store_we         = 1'b0;
    store_waddr      = slot;
    store_wdata      = sel_preset;
    case (a_cmd)
      CMD_TICK: begin
        if (running) begin
          if (cd_dec > UNDERFLOW_MARK) begin
            running_next   = 1'b0;
            countdown_next = sel_preset;
            done_next      = 1'b1;
          end else begin
            countdown_next = cd_dec;
          end
        end
      end
      CMD_SLEEP: begin
        if (sc_inc > sleep_limit) begin
          sleep_count_next = 16'd0;
          asleep_next      = 1'b1;
        end else begin
          sleep_count_next = sc_inc;
        end
      end
      CMD_LOAD: begin
        if (lidx_ok) begin
          store_we    = 1'b1;
          store_waddr = lidx_s;
          store_wdata = load_v;
          if (lidx_s == slot) begin
            sel_preset_next = load_v;
            if (!running) begin
              countdown_next = load_v;
            end
          end
        end
      end
      default: begin
        // Buttons: ignored while the relay is on; only wake a sleeping display.
        if (!running) begin
          if (asleep) begin
            asleep_next      = 1'b0;
            sleep_count_next = 16'd0;
          end else begin
            case (a_cmd)
              CMD_GRIND: begin
                countdown_next = sel_preset;
                running_next   = 1'b1;
              end
              CMD_LEFT, CMD_RIGHT: begin
                slot_next       = slot_nb;
                sel_preset_next = nb_preset;
                countdown_next  = nb_preset;
              end
              CMD_UP: begin
                store_we    = 1'b1;
                store_wdata = (up_sum > 17'(preset_limit)) ? 16'(preset_limit)
                                                           : up_sum[15:0];
                sel_preset_next = store_wdata;
                countdown_next  = store_wdata;
              end
              CMD_DOWN: begin
                store_we        = 1'b1;
                store_wdata     = (dn_diff > ROLLUNDER_MARK) ? 16'd0 : dn_diff;
                sel_preset_next = store_wdata;
                countdown_next  = store_wdata;
              end
              default: begin
              end
            endcase
          end
        end
      end
    endcase
  end

  assign slot_w = IDX_W'(slot_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        store[i] <= 16'd0;
      end
      sel_preset   <= 16'd0;
      slot         <= '0;
      countdown    <= 16'd0;
      running      <= 1'b0;
      sleep_count  <= 16'd0;
      asleep       <= 1'b0;
      preset_limit <= PRESET_LIMIT_RST;
      sleep_limit  <= SLEEP_LIMIT_RST;
      b_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PRESET_LIMIT: preset_limit <= cfg_data[10:0];
          REG_SLEEP_LIMIT:  sleep_limit  <= cfg_data;
          default: begin
          end
        endcase
      end
      if (b_move) begin
        b_valid <= a_valid;
      end
      if (b_load) begin
        if (store_we) begin
          store[store_waddr] <= store_wdata;
        end
        sel_preset  <= sel_preset_next;
        slot        <= slot_next;
        countdown   <= countdown_next;
        running     <= running_next;
        sleep_count <= sleep_count_next;
        asleep      <= asleep_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_load) begin
      b_res.relay_on             <= running_next;
      b_res.grind_done           <= done_next;
      b_res.display_asleep       <= asleep_next;
      b_res.selected_slot        <= slot_w[1:0];
      b_res.remaining_sixteenths <= countdown_next;
    end
  end

  // Digit split of the registered countdown.
  assign secs     = b_res.remaining_sixteenths[15:4];
  assign q10      = div10(19'(secs));
  assign q100     = div100(secs);
  assign tens_w   = q10[8:0] - 9'(q100) * 9'd10;
  assign tens_d   = tens_w[3:0];
  assign ones_d   = rem10(19'(secs));
  assign r5       = 19'(b_res.remaining_sixteenths) * 19'd5;
  assign tenths_d = rem10(19'(r5[18:3]));
  assign r25      = 21'(b_res.remaining_sixteenths) * 21'd25;
  assign hund_d   = rem10(r25[20:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_move) begin
      m_tvalid <= b_valid;
    end
    if (out_move && b_valid) begin
      m_tdata <= {3'b000, hund_d, tenths_d, ones_d, tens_d, b_res};
    end
  end

  // The selected preset copy always matches the store.
  `PCRT_ASSERT_IMP(a_mirror, 1'b1, sel_preset == store[slot])
  `PCRT_ASSERT_IMP(a_slot_range, 1'b1, 32'(slot) < NUM_SLOTS)
  // A finished countdown releases the relay and shows the reloaded preset.
  `PCRT_ASSERT_IMP(a_done_release, b_valid && b_res.grind_done,
                   !b_res.relay_on && (b_res.remaining_sixteenths == sel_preset))
  `PCRT_ASSERT_NXT(a_in_fill, s_tvalid && s_tready, a_valid)
  `PCRT_ASSERT_NXT(a_out_fill, b_valid && out_move, m_tvalid)

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for preset_countdown_relay_timer_top
// A short directed table of timer events is followed by random event traffic
// under six register settings and several flow-control patterns. Every result
// item is checked field by field against the table's expected readout or a predictor of the timer.
// ----------------------------------------------------------------------------
module testbench;
  import pcrt_pkg::*;

  localparam int STEP        = 4;
  localparam int QUIET_LIMIT = 4000;

  // Same layout as m_tdata, relay_on in bit 0.
  typedef struct packed {
    logic [3:0]  hundredths;
    logic [3:0]  tenths;
    logic [3:0]  ones;
    logic [3:0]  tens;
    logic [15:0] remaining;
    logic [1:0]  slot;
    logic        asleep;
    logic        done;
    logic        relay;
  } readout_t;

  typedef enum logic {ROW_EVENT, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    cmd_t        cmd;
    logic [1:0]  idx;
    logic [15:0] val;
    bit          fixed;
    readout_t    want;
  } plan_row_t;

  typedef struct {
    int preset_lim;
    int sleep_lim;
    int tx_idle;
    int rx_stall;
    int count;
    int hold_off;
    int pause_at;
  } phase_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // [1:0] load_index, [17:2] load_value, rest zero
  logic [2:0]  s_tuser = '0;   // [2:0] cmd
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;        // [0] relay_on, [1] grind_done, [2] display_asleep,
                               // [4:3] selected_slot, [20:5] remaining_sixteenths,
                               // [24:21] tens, [28:25] ones, [32:29] tenths,
                               // [36:33] hundredths
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;

  // Timer state as the predictor sees it.
  logic [15:0] slot_presets [4] = '{default: '0};
  logic [1:0]  cur_slot = '0;
  logic [15:0] countdown_left = '0;
  logic        relay_driven = 1'b0;
  logic [15:0] sleep_ticks = '0;
  logic        dozing = 1'b0;
  logic [10:0] preset_cap = PRESET_LIMIT_RST;
  logic [15:0] sleep_cap = SLEEP_LIMIT_RST;

  readout_t expected_readouts [$];

  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int hold_len = 0;
  int quiet_cycles = 0;
  int mismatches = 0;
  int items_sent = 0;
  int results_checked = 0;
  int countdowns_ended = 0;
  int sleeps_entered = 0;

  always #4 clk = ~clk;

  preset_countdown_relay_timer_top dut (.*);

  function automatic readout_t readout_of(logic relay, logic done, logic asleep,
                                          logic [1:0] slot, logic [15:0] rem);
    readout_t    r;
    int unsigned r32;
    int unsigned secs;
    r32          = rem;
    secs         = r32 >> 4;
    r.relay      = relay;
    r.done       = done;
    r.asleep     = asleep;
    r.slot       = slot;
    r.remaining  = rem;
    r.tens       = 4'((secs / 10) % 10);
    r.ones       = 4'(secs % 10);
    r.tenths     = 4'(((r32 * 5) >> 3) % 10);
    r.hundredths = 4'(((r32 * 25) >> 2) % 10);
    return r;
  endfunction

  // Applies one event to the predicted timer state and returns its readout.
  function automatic readout_t timer_step(cmd_t cmd, logic [1:0] idx, logic [15:0] val);
    logic        done;
    logic [15:0] v;
    int unsigned raised;
    done = 1'b0;
    case (cmd)
      CMD_TICK: begin
        if (relay_driven) begin
          countdown_left = countdown_left - 16'd1;
          if (countdown_left > UNDERFLOW_MARK) begin
            relay_driven   = 1'b0;
            countdown_left = slot_presets[cur_slot];
            done           = 1'b1;
            countdowns_ended++;
          end
        end
      end
      CMD_SLEEP: begin
        sleep_ticks = sleep_ticks + 16'd1;
        if (sleep_ticks > sleep_cap) begin
          sleep_ticks = '0;
          dozing      = 1'b1;
          sleeps_entered++;
        end
      end
      CMD_LOAD: begin
        v = val;
        if (v > preset_cap || (v % STEP) != 0) begin
          v = '0;
        end
        slot_presets[idx] = v;
        if (!relay_driven && idx == cur_slot) begin
          countdown_left = v;
        end
      end
      default: begin
        // Buttons are locked out while the relay is on; a sleeping display
        // only wakes up.
        if (!relay_driven) begin
          if (dozing) begin
            dozing      = 1'b0;
            sleep_ticks = '0;
          end else begin
            case (cmd)
              CMD_GRIND: begin
                countdown_left = slot_presets[cur_slot];
                relay_driven   = 1'b1;
              end
              CMD_LEFT: begin
                cur_slot       = cur_slot - 2'd1;
                countdown_left = slot_presets[cur_slot];
              end
              CMD_RIGHT: begin
                cur_slot       = cur_slot + 2'd1;
                countdown_left = slot_presets[cur_slot];
              end
              CMD_UP: begin
                raised = slot_presets[cur_slot] + STEP;
                if (raised > preset_cap) begin
                  raised = preset_cap;
                end
                slot_presets[cur_slot] = 16'(raised);
                countdown_left         = 16'(raised);
              end
              CMD_DOWN: begin
                v = slot_presets[cur_slot] - 16'(STEP);
                if (v > ROLLUNDER_MARK) begin
                  v = '0;
                end
                slot_presets[cur_slot] = v;
                countdown_left         = v;
              end
              default: ;
            endcase
          end
        end
      end
    endcase
    return readout_of(relay_driven, done, dozing, cur_slot, countdown_left);
  endfunction

  function automatic plan_row_t ev(cmd_t cmd, logic [1:0] idx, logic [15:0] val);
    plan_row_t r;
    r.kind  = ROW_EVENT;
    r.cmd   = cmd;
    r.idx   = idx;
    r.val   = val;
    r.fixed = 1'b0;
    r.want  = '0;
    return r;
  endfunction

  function automatic plan_row_t evx(cmd_t cmd, logic [1:0] idx, logic [15:0] val,
                                    logic relay, logic done, logic asleep,
                                    logic [1:0] slot, logic [15:0] rem);
    plan_row_t r;
    r       = ev(cmd, idx, val);
    r.fixed = 1'b1;
    r.want  = readout_of(relay, done, asleep, slot, rem);
    return r;
  endfunction

  function automatic plan_row_t reg_row(logic idx, logic [15:0] val);
    plan_row_t r;
    r      = ev(CMD_TICK, {1'b0, idx}, val);
    r.kind = ROW_REG;
    return r;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  task automatic send_event(cmd_t cmd, logic [1:0] idx, logic [15:0] val,
                            bit fixed, readout_t want);
    readout_t predicted;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, val, idx};
    s_tuser  <= cmd;
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
    predicted = timer_step(cmd, idx, val);
    expected_readouts.push_back(fixed ? want : predicted);
    items_sent++;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (expected_readouts.size() != 0);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_PRESET_LIMIT) begin
      preset_cap = val[10:0];
    end else begin
      sleep_cap = val;
    end
  endtask

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_len > 0) begin
      m_tready <= 1'b0;
      hold_len--;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Sampled mid-cycle: handshakes seen here complete at the next rising edge.
  always @(negedge clk) begin
    readout_t got;
    readout_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = readout_t'(m_tdata[36:0]);
        if (expected_readouts.size() == 0) begin
          $display("%0t: result %h arrived with nothing expected", $time, m_tdata);
          mismatches++;
        end else begin
          want = expected_readouts.pop_front();
          check_field("relay_on", want.relay, got.relay);
          check_field("grind_done", want.done, got.done);
          check_field("display_asleep", want.asleep, got.asleep);
          check_field("selected_slot", want.slot, got.slot);
          check_field("remaining_sixteenths", want.remaining, got.remaining);
          check_field("tens_digit", want.tens, got.tens);
          check_field("ones_digit", want.ones, got.ones);
          check_field("tenths_digit", want.tenths, got.tenths);
          check_field("hundredths_digit", want.hundredths, got.hundredths);
        end
        results_checked++;
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
          $display("FAIL preset_countdown_relay_timer_top");
          $finish;
        end
      end
    end
  end

  initial begin
    plan_row_t   plan [$];
    phase_t      phases [6];
    cmd_t        pick_cmd;
    int          sel;
    logic [1:0]  ridx;
    logic [15:0] rval;
    int unsigned span;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    plan = '{
      // Reset state, then a grind on an empty preset that ends at once.
      evx(CMD_TICK,  2'd0, 16'd0,     1'b0, 1'b0, 1'b0, 2'd0, 16'd0),
      evx(CMD_GRIND, 2'd0, 16'd0,     1'b1, 1'b0, 1'b0, 2'd0, 16'd0),
      evx(CMD_TICK,  2'd0, 16'd0,     1'b0, 1'b1, 1'b0, 2'd0, 16'd0),
      // Largest legal load, then loads that fail validation.
      evx(CMD_LOAD,  2'd0, 16'd1596,  1'b0, 1'b0, 1'b0, 2'd0, 16'd1596),
      evx(CMD_LOAD,  2'd1, 16'hFFFF,  1'b0, 1'b0, 1'b0, 2'd0, 16'd1596),
      evx(CMD_LOAD,  2'd2, 16'd6,     1'b0, 1'b0, 1'b0, 2'd0, 16'd1596),
      evx(CMD_LOAD,  2'd3, 16'd1600,  1'b0, 1'b0, 1'b0, 2'd0, 16'd1596),
      // Up saturates at the limit, down below zero clamps to zero.
      evx(CMD_UP,    2'd0, 16'd0,     1'b0, 1'b0, 1'b0, 2'd0, 16'd1596),
      evx(CMD_RIGHT, 2'd0, 16'd0,     1'b0, 1'b0, 1'b0, 2'd1, 16'd0),
      evx(CMD_DOWN,  2'd0, 16'd0,     1'b0, 1'b0, 1'b0, 2'd1, 16'd0),
      evx(CMD_UP,    2'd0, 16'd0,     1'b0, 1'b0, 1'b0, 2'd1, 16'd4),
      evx(CMD_LEFT,  2'd0, 16'd0,     1'b0, 1'b0, 1'b0, 2'd0, 16'd1596),
      evx(CMD_LEFT,  2'd0, 16'd0,     1'b0, 1'b0, 1'b0, 2'd3, 16'd0),
      evx(CMD_RIGHT, 2'd0, 16'd0,     1'b0, 1'b0, 1'b0, 2'd0, 16'd1596),
      // A short grind: buttons ignored, a load while running keeps the count.
      evx(CMD_LOAD,  2'd0, 16'd4,     1'b0, 1'b0, 1'b0, 2'd0, 16'd4),
      evx(CMD_GRIND, 2'd0, 16'd0,     1'b1, 1'b0, 1'b0, 2'd0, 16'd4),
      evx(CMD_UP,    2'd0, 16'd0,     1'b1, 1'b0, 1'b0, 2'd0, 16'd4),
      evx(CMD_LOAD,  2'd0, 16'd12,    1'b1, 1'b0, 1'b0, 2'd0, 16'd4),
      ev(CMD_TICK,   2'd0, 16'd0),
      ev(CMD_TICK,   2'd0, 16'd0),
      ev(CMD_TICK,   2'd0, 16'd0),
      ev(CMD_TICK,   2'd0, 16'd0),
      evx(CMD_TICK,  2'd0, 16'd0,     1'b0, 1'b1, 1'b0, 2'd0, 16'd12),
      // Sleep on the first tick, large countdowns, wake-up by a button.
      reg_row(REG_SLEEP_LIMIT, 16'd0),
      reg_row(REG_PRESET_LIMIT, 16'd2047),
      evx(CMD_SLEEP, 2'd0, 16'd0,     1'b0, 1'b0, 1'b1, 2'd0, 16'd12),
      evx(CMD_LOAD,  2'd0, 16'd2044,  1'b0, 1'b0, 1'b1, 2'd0, 16'd2044),
      evx(CMD_GRIND, 2'd0, 16'd0,     1'b0, 1'b0, 1'b0, 2'd0, 16'd2044),
      evx(CMD_GRIND, 2'd0, 16'd0,     1'b1, 1'b0, 1'b0, 2'd0, 16'd2044),
      evx(CMD_SLEEP, 2'd0, 16'd0,     1'b1, 1'b0, 1'b1, 2'd0, 16'd2044),
      ev(CMD_TICK,   2'd0, 16'd0)
    };
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        write_reg(plan[i].idx[0], plan[i].val);
      end else begin
        send_event(plan[i].cmd, plan[i].idx, plan[i].val, plan[i].fixed, plan[i].want);
      end
    end

    phases[0] = '{1596, 20, 0, 0, 200, 0, -1};
    phases[1] = '{40, 12, 85, 0, 200, 0, -1};
    phases[2] = '{0, 0, 0, 85, 150, 0, -1};
    phases[3] = '{2047, 65534, 7, 7, 200, 0, -1};
    phases[4] = '{$urandom_range(1596), $urandom_range(40), 0, 0, 250, 400, -1};
    phases[5] = '{1596, 65535, 7, 7, 300, 0, 150};

    foreach (phases[p]) begin
      write_reg(REG_PRESET_LIMIT, 16'(phases[p].preset_lim));
      write_reg(REG_SLEEP_LIMIT, 16'(phases[p].sleep_lim));
      tx_idle_pct  = phases[p].tx_idle;
      rx_stall_pct = phases[p].rx_stall;
      hold_len     = phases[p].hold_off;
      for (int n = 0; n < phases[p].count; n++) begin
        sel  = $urandom_range(99);
        ridx = 2'($urandom_range(3));
        rval = 16'($urandom);
        if (sel < 38) begin
          pick_cmd = CMD_TICK;
        end else if (sel < 48) begin
          pick_cmd = CMD_SLEEP;
        end else if (sel < 58) begin
          pick_cmd = CMD_GRIND;
        end else if (sel < 64) begin
          pick_cmd = CMD_LEFT;
        end else if (sel < 70) begin
          pick_cmd = CMD_RIGHT;
        end else if (sel < 78) begin
          pick_cmd = CMD_UP;
        end else if (sel < 84) begin
          pick_cmd = CMD_DOWN;
        end else begin
          pick_cmd = CMD_LOAD;
          // Mostly short legal presets so that countdowns run out often.
          span = (preset_cap < 11'd64) ? preset_cap : 64;
          case ($urandom_range(9))
            0, 1, 2, 3, 4, 5, 6: rval = 16'(4 * $urandom_range(span / 4));
            7: rval = 16'(4 * $urandom_range(preset_cap / 4));
            default: ;
          endcase
        end
        send_event(pick_cmd, ridx, rval, 1'b0, '0);
        if (n == phases[p].pause_at || $urandom_range(199) == 0) begin
          wait_drained();
        end
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);

    $display("Sent %0d items under six register settings and checked %0d results;",
             items_sent, results_checked);
    $display("%0d countdowns ran out and the display went to sleep %0d times.",
             countdowns_ended, sleeps_entered);
    if (mismatches == 0 && expected_readouts.size() == 0) begin
      $display("PASS preset_countdown_relay_timer_top");
    end else begin
      $display("FAIL preset_countdown_relay_timer_top");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+design
design/pcrt_pkg.sv
design/preset_countdown_relay_timer_top.sv
tb/testbench.sv
